// ===== sv/rgbl_pkg.sv =====
// Shared widths, types and elaboration-time lookup tables for the lightness pipeline.
`default_nettype none

package rgbl_pkg;

  // Field and datapath widths.
  localparam int CHAN_W  = 8;
  localparam int LIN_W   = 16;
  localparam int LUMA_W  = 16;
  localparam int LEVEL_W = 8;
  localparam int THR_W   = LUMA_W + 1;
  localparam int TAB_N   = 1 << CHAN_W;
  localparam int LEVEL_N = 1 << LEVEL_W;

  // Luminance weights in Q0.16; they sum to exactly 65536.
  localparam logic [15:0] W_RED   = 16'd13938;
  localparam logic [15:0] W_GREEN = 16'd46869;
  localparam logic [15:0] W_BLUE  = 16'd4729;
  localparam int WR_W = $clog2(int'(W_RED) + 1);
  localparam int WG_W = $clog2(int'(W_GREEN) + 1);
  localparam int WB_W = $clog2(int'(W_BLUE) + 1);

  // Weighted sum of three Q0.16 values stays below 2^32.
  localparam int SUM_W = LIN_W + 16;

  // Scale of the linear segment: level = y * 24389 * 255 / (27 * 100 * 65536).
  localparam logic [63:0] LIN_DEN = 64'd27 * 64'd100 * 64'd65536;

  typedef logic [LIN_W-1:0] lin_tab_t [TAB_N];
  typedef logic [THR_W-1:0] thr_tab_t [LEVEL_N];
  typedef logic [191:0] big_t;

  // Word carried through the threshold search stages.
  typedef struct packed {
    logic [LUMA_W-1:0]  luma;
    logic [LEVEL_W-1:0] level;
  } search_t;

  // True when y^5 * 255^11 <= c^11 * 65536^5, that is y <= 65536 * (c/255)^2.2.
  function automatic logic gamma_fits(input logic [31:0] y, input logic [31:0] c);
    big_t lhs;
    big_t rhs;
    lhs = big_t'(1);
    rhs = big_t'(1);
    for (int k = 0; k < 5; k++) lhs = lhs * big_t'(y);
    for (int k = 0; k < 11; k++) lhs = lhs * big_t'(255);
    for (int k = 0; k < 11; k++) rhs = rhs * big_t'(c);
    rhs = rhs << 80;
    return lhs <= rhs;
  endfunction

  // Largest Q0.16 value not above the gamma 2.2 curve for channel code c.
  function automatic logic [LIN_W-1:0] lin_of(input logic [31:0] c);
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    lo = 32'd0;
    hi = 32'd65535;
    while (lo < hi) begin
      mid = (lo + hi + 32'd1) >> 1;
      if (gamma_fits(mid, c)) begin
        lo = mid;
      end else begin
        hi = mid - 32'd1;
      end
    end
    return lo[LIN_W-1:0];
  endfunction

  function automatic lin_tab_t build_lin();
    lin_tab_t tab;
    for (int c = 0; c < TAB_N; c++) tab[c] = lin_of(32'(c));
    return tab;
  endfunction

  // Output level for a Q0.16 luminance. Below the knee it is the largest n with
  // n * 27 * 100 * 65536 <= y * 24389 * 255; above it the largest n with
  // (100n + 4080)^3 * 65536 <= y * 29580^3. Both are found by binary search.
  function automatic logic [31:0] level_of(input logic [31:0] y);
    logic [63:0] n;
    logic [63:0] full;
    logic [63:0] bound;
    logic [63:0] t;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    logic        lin;
    logic        fits;
    full = 64'd29580 * 64'd29580 * 64'd29580;
    lin = {32'd0, y} * 64'd24389 <= 64'd216 * 64'd65536;
    if (lin) begin
      bound = {32'd0, y} * 64'd24389 * 64'd255;
    end else begin
      bound = {32'd0, y} * full;
    end
    lo = 32'd0;
    hi = 32'd255;
    while (lo < hi) begin
      mid = (lo + hi + 32'd1) >> 1;
      t = {32'd0, mid} * 64'd100 + 64'd4080;
      if (lin) begin
        fits = {32'd0, mid} * LIN_DEN <= bound;
      end else begin
        fits = t * t * t * 64'd65536 <= bound;
      end
      if (fits) begin
        lo = mid;
      end else begin
        hi = mid - 32'd1;
      end
    end
    n = {32'd0, lo};
    if (n > 64'd255) n = 64'd255;
    return n[31:0];
  endfunction

  // Smallest luminance that reaches each output level; 65536 where none does.
  function automatic thr_tab_t build_thr();
    thr_tab_t tab;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    for (int n = 0; n < LEVEL_N; n++) begin
      lo = 32'd0;
      hi = 32'd65536;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (level_of(mid) >= 32'(n)) begin
          hi = mid;
        end else begin
          lo = mid + 32'd1;
        end
      end
      tab[n] = lo[THR_W-1:0];
    end
    return tab;
  endfunction

  localparam lin_tab_t LIN_TAB = build_lin();
  localparam thr_tab_t THR_TAB = build_thr();

endpackage

`default_nettype wire

// ===== sv/rgb_to_cie_lightness.sv =====
// Top level: RGB pixel to CIE L* lightness byte, fully pipelined.
//
// Accepts one pixel per clock while the output is not stalled and returns its
// CIE L* lightness scaled so that 100 maps to 255, truncated. Each pixel passes
// through registered stages for the gamma table lookup, the weighting
// multiplies and the luminance sum, then through a binary search of the
// luminance against a 256-entry table of level thresholds, one result bit per
// stage. Every stage holds its own valid bit, so stalls on the output fill
// bubbles first and nothing is lost or repeated.
// Full white gives 254.
`default_nettype none

module rgb_to_cie_lightness (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [rgbl_pkg::CHAN_W-1:0]   in_red,
  input  wire logic [rgbl_pkg::CHAN_W-1:0]   in_green,
  input  wire logic [rgbl_pkg::CHAN_W-1:0]   in_blue,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [rgbl_pkg::LEVEL_W-1:0]       out_lightness
);
  import rgbl_pkg::*;

  logic              luma_valid;
  logic [LUMA_W-1:0] luma;
  logic              step_valid [LEVEL_W+1];
  logic              step_ready [LEVEL_W+1];
  search_t           step_word  [LEVEL_W+1];

  // Luminance front end.
  rgbl_luma u_luma (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_red    (in_red),
    .in_green  (in_green),
    .in_blue   (in_blue),
    .out_valid (luma_valid),
    .out_ready (step_ready[0]),
    .out_luma  (luma)
  );

  // The search starts from level zero.
  assign step_valid[0] = luma_valid;
  assign step_word[0]  = '{luma: luma, level: '0};

  // One search stage per result bit, most significant first.
  for (genvar k = 0; k < LEVEL_W; k++) begin : g_step
    rgbl_search_step #(
      .STEP_BIT (LEVEL_W - 1 - k)
    ) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (step_valid[k]),
      .in_ready  (step_ready[k]),
      .in_word   (step_word[k]),
      .out_valid (step_valid[k+1]),
      .out_ready (step_ready[k+1]),
      .out_word  (step_word[k+1])
    );
  end

  assign step_ready[LEVEL_W] = out_ready;
  assign out_valid           = step_valid[LEVEL_W];
  assign out_lightness       = step_word[LEVEL_W].level;

endmodule

`default_nettype wire

// ===== sv/rgbl_luma.sv =====
// Three-stage luminance front end: gamma lookup, weighting multiplies and sum.
`default_nettype none

module rgbl_luma (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [rgbl_pkg::CHAN_W-1:0]  in_red,
  input  wire logic [rgbl_pkg::CHAN_W-1:0]  in_green,
  input  wire logic [rgbl_pkg::CHAN_W-1:0]  in_blue,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [rgbl_pkg::LUMA_W-1:0]       out_luma
);
  import rgbl_pkg::*;

  logic                  v1_r, v2_r, v3_r;
  logic                  rdy1, rdy2, rdy3;
  logic [LIN_W-1:0]      lin_red_r, lin_green_r, lin_blue_r;
  logic [LIN_W+WR_W-1:0] prod_red_r;
  logic [LIN_W+WG_W-1:0] prod_green_r;
  logic [LIN_W+WB_W-1:0] prod_blue_r;
  logic [SUM_W-1:0]      sum_nxt;
  logic [LUMA_W-1:0]     luma_r;

  // A stage takes a new word when it is empty or its word moves on.
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
  end

  // Stage one: linearise each channel through the gamma table.
  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      lin_red_r   <= LIN_TAB[in_red];
      lin_green_r <= LIN_TAB[in_green];
      lin_blue_r  <= LIN_TAB[in_blue];
    end
  end

  // Stage two: weight each linear channel.
  always_ff @(posedge clk) begin
    if (v1_r && rdy2) begin
      prod_red_r   <= lin_red_r * W_RED[WR_W-1:0];
      prod_green_r <= lin_green_r * W_GREEN[WG_W-1:0];
      prod_blue_r  <= lin_blue_r * W_BLUE[WB_W-1:0];
    end
  end

  // Stage three: add the weighted channels and drop the fraction.
  assign sum_nxt = SUM_W'(prod_red_r) + SUM_W'(prod_green_r) + SUM_W'(prod_blue_r);

  always_ff @(posedge clk) begin
    if (v2_r && rdy3) begin
      luma_r <= sum_nxt[SUM_W-1 -: LUMA_W];
    end
  end

  assign out_valid = v3_r;
  assign out_luma  = luma_r;

endmodule

`default_nettype wire

// ===== sv/rgbl_search_step.sv =====
// One registered step of the binary search for the output level against the threshold table.
`default_nettype none

module rgbl_search_step #(
  parameter int STEP_BIT = 0
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire rgbl_pkg::search_t in_word,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output rgbl_pkg::search_t      out_word
);
  import rgbl_pkg::*;

  logic [LEVEL_W-1:0] cand;
  logic               take;
  search_t            word_nxt;
  search_t            word_r;
  logic               valid_r;

  // Try setting this step's bit; keep it when the luminance reaches that level.
  assign cand = in_word.level | (LEVEL_W'(1) << STEP_BIT);
  assign take = THR_TAB[cand] <= {1'b0, in_word.luma};

  always_comb begin
    word_nxt = in_word;
    if (take) word_nxt.level = cand;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire
